// ===== rtl/core/sdq_pkg.sv =====
package sdq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TAG_WIDTH_DEF   = 16;

    // Width of the dividend and of the quotient in the tempo divider.
    localparam int DIV_STEPS = 64;

    typedef enum logic [1:0] {
        MODE_PUSH  = 2'd0,
        MODE_POP   = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_TEMPO = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_FULL       = 2'd1,
        ST_EMPTY      = 2'd2,
        ST_ZERO_TEMPO = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH_RD,
        S_PUSH_CMP,
        S_POP_RD,
        S_POP_HEAD,
        S_ADJ_RD,
        S_ADJ_MUL_LO,
        S_ADJ_MUL_HI,
        S_ADJ_START,
        S_ADJ_DIV,
        S_FINISH
    } state_t;

    typedef struct packed {
        mode_t       mode;
        logic [63:0] event_time;
        logic [15:0] entry_tag;
        logic [31:0] tempo_from;
        logic [31:0] tempo_to;
    } item_t;

    typedef struct packed {
        logic [15:0] popped_tag;
        logic        pop_valid;
        logic [63:0] head_time;
        logic        queue_empty;
        logic [4:0]  entry_count;
        status_t     status;
    } result_t;

endpackage

// ===== rtl/core/sdq_div.sv =====
module sdq_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);

    localparam int CNT_W = $clog2(sdq_pkg::DIV_STEPS + 1);

    logic [31:0]      rem_reg;
    logic [63:0]      quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [32:0]      trial;
    logic             take;

    // Restoring division, one quotient bit per cycle. The remainder stays
    // below the divisor, so 32 bits hold it.
    assign trial = {rem_reg, quo_reg[63]};
    assign take  = (trial >= {1'b0, divisor});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(sdq_pkg::DIV_STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? 32'(trial - {1'b0, divisor}) : trial[31:0];
            quo_reg <= {quo_reg[62:0], take};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/core/sorted_deadline_queue.sv =====
// Channel | Direction | Handshake                    | Payload
// item    | in        | item_valid / item_stall      | sdq_pkg::item_t
// result  | out       | result_valid / result_stall  | sdq_pkg::result_t
//
// Push walks from the tail toward the head, moving each later entry up one place before
// writing the new one; pop reloads the new head from memory unless the queue empties.
// Clear only zeroes the count. Tempo adjust reads, multiplies and divides each held entry in
// turn, using the 64-step divider; one entry is read, rescaled and written back at a time.
// Reset is asynchronous and clears only the control state; the entry memory needs no pass.
// A new item is taken while an earlier result still waits in the output register.
module sorted_deadline_queue #(
    parameter int QUEUE_DEPTH = sdq_pkg::QUEUE_DEPTH_DEF,
    parameter int TAG_WIDTH   = sdq_pkg::TAG_WIDTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  sdq_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output sdq_pkg::result_t result
);

    // IW indexes the memory, CW holds a count from zero up to the depth.
    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // The entries sit in a circular buffer; logical position zero is the head.
    logic [63:0]          time_mem [QUEUE_DEPTH];
    logic [TAG_WIDTH-1:0] tag_mem  [QUEUE_DEPTH];

    sdq_pkg::state_t  state_reg, state_next;
    sdq_pkg::item_t   op_reg, op_next;
    sdq_pkg::result_t res_reg, res_next;
    sdq_pkg::status_t status_reg, status_next;

    logic                 res_valid_reg, res_valid_next;
    logic [IW-1:0]        head_ptr_reg, head_ptr_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic [63:0]          head_time_reg, head_time_next;
    logic [TAG_WIDTH-1:0] head_tag_reg, head_tag_next;
    logic [15:0]          popped_reg, popped_next;
    logic                 pop_valid_reg, pop_valid_next;
    logic [63:0]          prod_reg, prod_next;
    logic [31:0]          off_hi_reg, off_hi_next;

    logic                 rd_en;
    logic [IW-1:0]        rd_addr;
    logic [63:0]          rd_time_reg;
    logic [TAG_WIDTH-1:0] rd_tag_reg;
    logic                 wr_en;
    logic                 wr_tag_en;
    logic [IW-1:0]        wr_addr;
    logic [63:0]          wr_time;
    logic [TAG_WIDTH-1:0] wr_tag;

    logic                 div_start;
    logic                 div_done;
    logic [63:0]          div_quot;

    logic [63:0]          tag_wide;
    logic [TAG_WIDTH-1:0] tag_in;
    logic [63:0]          head_tag_wide;
    logic [63:0]          offset;
    logic [63:0]          prod_lo;
    logic [31:0]          prod_hi;
    logic [IW-1:0]        head_ptr_inc;

    // Maps a logical position to its memory address.
    function automatic logic [IW-1:0] phys(input logic [IW-1:0] head, input logic [CW-1:0] lidx);
        logic [CW:0] sum;
        sum = (CW + 1)'(head) + (CW + 1)'(lidx);
        if (sum >= (CW + 1)'(QUEUE_DEPTH))
        begin
            sum = sum - (CW + 1)'(QUEUE_DEPTH);
        end
        return sum[IW-1:0];
    endfunction

    // Tags wider than the input field are zero-extended, narrower ones truncated.
    assign tag_wide      = 64'(op_reg.entry_tag);
    assign tag_in        = tag_wide[TAG_WIDTH-1:0];
    assign head_tag_wide = 64'(head_tag_reg);

    // The 64 by 32 product, kept modulo 2^64, is built from two 32 by 32 halves
    // in consecutive cycles; the upper half only contributes its low word.
    assign offset  = rd_time_reg - op_reg.event_time;
    assign prod_lo = 64'(offset[31:0]) * 64'(op_reg.tempo_from);
    assign prod_hi = off_hi_reg * op_reg.tempo_from;

    assign head_ptr_inc = (head_ptr_reg == IW'(QUEUE_DEPTH - 1)) ? '0 : head_ptr_reg + IW'(1);

    sdq_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (op_reg.tempo_to),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Entry memory: one write and one registered read per cycle. The sequencer
    // never reads an entry in the cycle it writes that entry, so no bypass is needed.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            time_mem[wr_addr] <= wr_time;
            if (wr_tag_en)
            begin
                tag_mem[wr_addr] <= wr_tag;
            end
        end
        if (rd_en)
        begin
            rd_time_reg <= time_mem[rd_addr];
            rd_tag_reg  <= tag_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sdq_pkg::S_IDLE;
            res_valid_reg <= 1'b0;
            head_ptr_reg  <= '0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            head_ptr_reg  <= head_ptr_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        res_reg       <= res_next;
        status_reg    <= status_next;
        idx_reg       <= idx_next;
        head_time_reg <= head_time_next;
        head_tag_reg  <= head_tag_next;
        popped_reg    <= popped_next;
        pop_valid_reg <= pop_valid_next;
        prod_reg      <= prod_next;
        off_hi_reg    <= off_hi_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        res_next       = res_reg;
        status_next    = status_reg;
        res_valid_next = res_valid_reg;
        head_ptr_next  = head_ptr_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        head_time_next = head_time_reg;
        head_tag_next  = head_tag_reg;
        popped_next    = popped_reg;
        pop_valid_next = pop_valid_reg;
        prod_next      = prod_reg;
        off_hi_next    = off_hi_reg;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_tag_en      = 1'b0;
        wr_addr        = '0;
        wr_time        = '0;
        wr_tag         = '0;
        div_start      = 1'b0;

        // The held result leaves on its own transfer, independent of the sequencer.
        if (res_valid_reg && !result_stall)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            sdq_pkg::S_IDLE:
            begin
                if (item_valid)
                begin
                    op_next        = item;
                    popped_next    = '0;
                    pop_valid_next = 1'b0;
                    status_next    = sdq_pkg::ST_OK;
                    state_next     = sdq_pkg::S_FINISH;
                    unique case (item.mode)
                        sdq_pkg::MODE_PUSH:
                        begin
                            if (count_reg == CW'(QUEUE_DEPTH))
                            begin
                                status_next = sdq_pkg::ST_FULL;
                            end
                            else
                            begin
                                idx_next   = count_reg;
                                state_next = sdq_pkg::S_PUSH_RD;
                            end
                        end
                        sdq_pkg::MODE_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = sdq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                popped_next    = head_tag_wide[15:0];
                                pop_valid_next = 1'b1;
                                head_ptr_next  = head_ptr_inc;
                                count_next     = count_reg - CW'(1);
                                if (count_reg != CW'(1))
                                begin
                                    state_next = sdq_pkg::S_POP_RD;
                                end
                            end
                        end
                        sdq_pkg::MODE_CLEAR:
                        begin
                            count_next = '0;
                        end
                        sdq_pkg::MODE_TEMPO:
                        begin
                            if (item.tempo_to == '0)
                            begin
                                status_next = sdq_pkg::ST_ZERO_TEMPO;
                            end
                            else if (count_reg != '0)
                            begin
                                idx_next   = '0;
                                state_next = sdq_pkg::S_ADJ_RD;
                            end
                        end
                        default:
                        begin
                            state_next = sdq_pkg::S_FINISH;
                        end
                    endcase
                end
            end

            // Insertion walks back from the tail, moving later entries up one place.
            sdq_pkg::S_PUSH_RD:
            begin
                if (idx_reg == '0)
                begin
                    wr_en          = 1'b1;
                    wr_tag_en      = 1'b1;
                    wr_addr        = phys(head_ptr_reg, idx_reg);
                    wr_time        = op_reg.event_time;
                    wr_tag         = tag_in;
                    head_time_next = op_reg.event_time;
                    head_tag_next  = tag_in;
                    count_next     = count_reg + CW'(1);
                    state_next     = sdq_pkg::S_FINISH;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = phys(head_ptr_reg, idx_reg - CW'(1));
                    state_next = sdq_pkg::S_PUSH_CMP;
                end
            end

            sdq_pkg::S_PUSH_CMP:
            begin
                wr_en     = 1'b1;
                wr_tag_en = 1'b1;
                wr_addr   = phys(head_ptr_reg, idx_reg);
                if (rd_time_reg > op_reg.event_time)
                begin
                    wr_time    = rd_time_reg;
                    wr_tag     = rd_tag_reg;
                    idx_next   = idx_reg - CW'(1);
                    state_next = sdq_pkg::S_PUSH_RD;
                end
                else
                begin
                    wr_time    = op_reg.event_time;
                    wr_tag     = tag_in;
                    count_next = count_reg + CW'(1);
                    state_next = sdq_pkg::S_FINISH;
                end
            end

            sdq_pkg::S_POP_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = head_ptr_reg;
                state_next = sdq_pkg::S_POP_HEAD;
            end

            sdq_pkg::S_POP_HEAD:
            begin
                head_time_next = rd_time_reg;
                head_tag_next  = rd_tag_reg;
                state_next     = sdq_pkg::S_FINISH;
            end

            sdq_pkg::S_ADJ_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = phys(head_ptr_reg, idx_reg);
                state_next = sdq_pkg::S_ADJ_MUL_LO;
            end

            sdq_pkg::S_ADJ_MUL_LO:
            begin
                prod_next   = prod_lo;
                off_hi_next = offset[63:32];
                state_next  = sdq_pkg::S_ADJ_MUL_HI;
            end

            sdq_pkg::S_ADJ_MUL_HI:
            begin
                prod_next  = prod_reg + {prod_hi, 32'd0};
                state_next = sdq_pkg::S_ADJ_START;
            end

            sdq_pkg::S_ADJ_START:
            begin
                div_start  = 1'b1;
                state_next = sdq_pkg::S_ADJ_DIV;
            end

            sdq_pkg::S_ADJ_DIV:
            begin
                if (div_done)
                begin
                    wr_en   = 1'b1;
                    wr_addr = phys(head_ptr_reg, idx_reg);
                    wr_time = op_reg.event_time + div_quot;
                    if (idx_reg == '0)
                    begin
                        head_time_next = op_reg.event_time + div_quot;
                    end
                    idx_next = idx_reg + CW'(1);
                    if (idx_next == count_reg)
                    begin
                        state_next = sdq_pkg::S_FINISH;
                    end
                    else
                    begin
                        state_next = sdq_pkg::S_ADJ_RD;
                    end
                end
            end

            // Wait here until the output register is free or is being emptied.
            sdq_pkg::S_FINISH:
            begin
                if (!res_valid_reg || !result_stall)
                begin
                    res_valid_next       = 1'b1;
                    res_next.popped_tag  = popped_reg;
                    res_next.pop_valid   = pop_valid_reg;
                    res_next.head_time   = (count_reg == '0) ? '0 : head_time_reg;
                    res_next.queue_empty = (count_reg == '0);
                    res_next.entry_count = 5'(count_reg);
                    res_next.status      = status_reg;
                    state_next           = sdq_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = sdq_pkg::S_IDLE;
            end
        endcase
    end

    assign item_stall   = (state_reg != sdq_pkg::S_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // The fill count never passes the depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
    else $error("fill count beyond queue depth");

    // An accepted item holds off the next one in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> item_stall)
    else $error("second item accepted back to back");

    // A removed entry is only ever reported with an ok status.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.pop_valid) |-> (res_reg.status == sdq_pkg::ST_OK))
    else $error("pop reported together with an error status");

    // The divider only finishes while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == sdq_pkg::S_ADJ_DIV))
    else $error("divider finished outside the rescale step");

endmodule
